FILE: rtl/tnds_pkg.sv
// ----------------------------------------------------------------------------
// tnds_pkg: shared types and constants for the top-N dot-product search
// Holds field widths, default sizes, command codes and the record that goes
// from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package tnds_pkg;

  // Field widths fixed by the interface.
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 8;
  localparam int ELEM_W  = 16;
  localparam int ID_W    = 20;
  localparam int RANK_W  = 5;
  localparam int SCORE_W = 48;
  localparam int PROD_W  = 2 * ELEM_W;

  // Default sizes for the top-level parameters.
  localparam int TOP_N_DEF      = 25;
  localparam int VECTOR_DIM_DEF = 256;
  localparam int VOCAB_SIZE_DEF = 1048576;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Saturation limits of the Q24.24 accumulator.
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // Command codes carried by the command field.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_CAND   = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_CLEAR  = 2'd3
  } op_kind_t;

  // Work record handed from the front end to the back end.
  typedef struct packed {
    op_kind_t                  kind;
    logic signed [PROD_W-1:0]  prod;
    logic [ID_W-1:0]           id;
    logic                      last;
    logic                      excluded;
    logic                      id_ok;
  } op_t;

endpackage

`default_nettype wire

FILE: rtl/tnds_front.sv
// ----------------------------------------------------------------------------
// tnds_front: input side of the top-N dot-product search
// Accepts input beats, keeps the query vector, reads the matching query
// element and forms the product, then hands work records to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tnds_front #(
  parameter int VECTOR_DIM = tnds_pkg::VECTOR_DIM_DEF,
  parameter int VOCAB_SIZE = tnds_pkg::VOCAB_SIZE_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [tnds_pkg::CMD_W-1:0]         command,
  input  wire logic [tnds_pkg::IDX_W-1:0]         elem_index,
  input  wire logic signed [tnds_pkg::ELEM_W-1:0] elem_value,
  input  wire logic [tnds_pkg::ID_W-1:0]          cand_id,
  input  wire logic                               cand_last,
  input  wire logic                               cand_excluded,
  output tnds_pkg::op_t                           push_op,
  output logic                                    push_valid,
  input  wire logic                               push_ready
);

  localparam int IDX_SPAN  = 1 << tnds_pkg::IDX_W;
  localparam int MEM_DEPTH = (VECTOR_DIM < IDX_SPAN) ? VECTOR_DIM : IDX_SPAN;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int ELEM_W    = tnds_pkg::ELEM_W;
  localparam int PROD_W    = tnds_pkg::PROD_W;
  localparam int ID_W      = tnds_pkg::ID_W;

  // Query vector storage; entries hold garbage until loaded.
  logic signed [ELEM_W-1:0] qmem [MEM_DEPTH];
  logic signed [ELEM_W-1:0] q_rdata;

  // Decoded view of the incoming beat.
  tnds_pkg::op_kind_t in_kind;
  logic               in_fire;
  logic               in_range;
  logic               in_id_ok;
  logic [ADDR_W-1:0]  in_addr;

  // Stage register between the query read and the queue.
  logic                     s1_valid;
  tnds_pkg::op_kind_t       s1_kind;
  logic signed [ELEM_W-1:0] s1_eval;
  logic                     s1_in_range;
  logic [ID_W-1:0]          s1_id;
  logic                     s1_last;
  logic                     s1_excluded;
  logic                     s1_id_ok;
  logic signed [PROD_W-1:0] s1_prod;

  // Classify the beat and check its index and id against the sizes.
  always_comb begin
    in_kind  = tnds_pkg::op_kind_t'(command);
    in_fire  = in_valid && in_ready;
    in_range = 32'(elem_index) < 32'(VECTOR_DIM);
    in_id_ok = 32'(cand_id) < 32'(VOCAB_SIZE);
    in_addr  = elem_index[ADDR_W-1:0];
  end

  // The stage accepts a new beat when empty or when it drains this cycle.
  assign in_ready = !s1_valid || push_ready;

  // Query load writes the store; every accepted beat reads it.
  always_ff @(posedge clk) begin
    if (in_fire && (in_kind == tnds_pkg::CMD_LOAD) && in_range) begin
      qmem[in_addr] <= elem_value;
    end
    if (in_fire) begin
      q_rdata <= qmem[in_addr];
    end
  end

  // Stage occupancy; query loads finish here and do not go further.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= (in_kind != tnds_pkg::CMD_LOAD);
    end else if (push_ready) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind     <= in_kind;
      s1_eval     <= elem_value;
      s1_in_range <= in_range;
      s1_id       <= cand_id;
      s1_last     <= cand_last;
      s1_excluded <= cand_excluded;
      s1_id_ok    <= in_id_ok;
    end
  end

  // Exact Q8.24 product; an element past the vector end adds nothing.
  always_comb begin
    s1_prod = '0;
    if (s1_in_range) begin
      s1_prod = PROD_W'(q_rdata) * PROD_W'(s1_eval);
    end
  end

  // Work record toward the queue.
  always_comb begin
    push_valid        = s1_valid;
    push_op.kind      = s1_kind;
    push_op.prod      = s1_prod;
    push_op.id        = s1_id;
    push_op.last      = s1_last;
    push_op.excluded  = s1_excluded;
    push_op.id_ok     = s1_id_ok;
  end

endmodule

`default_nettype wire

FILE: rtl/tnds_queue.sv
// ----------------------------------------------------------------------------
// tnds_queue: short queue between front and back
// Holds a few work records so that the front and the back stall on their own.
// ----------------------------------------------------------------------------
`default_nettype none

module tnds_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tnds_pkg::op_t push_op,
  input  wire logic          push_valid,
  output logic               push_ready,
  output tnds_pkg::op_t      pop_op,
  output logic               pop_valid,
  input  wire logic          pop_ready
);

  localparam int DEPTH = tnds_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  tnds_pkg::op_t       slots [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [PTR_W:0]      count;
  logic                push_fire;
  logic                pop_fire;

  // Handshake on both sides.
  always_comb begin
    push_ready = (count != (PTR_W+1)'(DEPTH));
    pop_valid  = (count != '0);
    push_fire  = push_valid && push_ready;
    pop_fire   = pop_valid && pop_ready;
    pop_op     = slots[rd_ptr];
  end

  // Record storage.
  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill count; the depth is a power of two so pointers wrap.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tnds_back.sv
// ----------------------------------------------------------------------------
// tnds_back: execution side of the top-N dot-product search
// Accumulates products with saturation, inserts finished scores into the
// sorted list through a row of compare cells, and plays the list out on a
// report.
// ----------------------------------------------------------------------------
`default_nettype none

module tnds_back #(
  parameter int TOP_N = tnds_pkg::TOP_N_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tnds_pkg::op_t                       pop_op,
  input  wire logic                                pop_valid,
  output logic                                     pop_ready,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [tnds_pkg::RANK_W-1:0]              rank,
  output logic [tnds_pkg::ID_W-1:0]                word_id,
  output logic signed [tnds_pkg::SCORE_W-1:0]      score,
  output logic                                     filled,
  output logic                                     last_result
);

  localparam int SCORE_W = tnds_pkg::SCORE_W;
  localparam int SUM_W   = SCORE_W + 1;
  localparam int ID_W    = tnds_pkg::ID_W;
  localparam int RANK_W  = tnds_pkg::RANK_W;
  localparam int CNT_W   = (TOP_N > 1) ? $clog2(TOP_N) : 1;

  typedef enum logic {
    ST_RUN,
    ST_REPORT
  } state_t;

  state_t st;
  logic [CNT_W-1:0] rpt_cnt;

  // Accumulator and candidate state.
  logic signed [SCORE_W-1:0] acc;
  logic                      skip;
  logic signed [SUM_W-1:0]   sum_wide;
  logic signed [SCORE_W-1:0] sum_sat;
  logic                      sum_pos;
  logic                      skip_now;

  // Score waiting for insertion.
  logic                      ins_pending;
  logic signed [SCORE_W-1:0] ins_score;
  logic [ID_W-1:0]           ins_id;

  // Sorted list, best first.
  logic signed [SCORE_W-1:0] best_score [TOP_N];
  logic [ID_W-1:0]           best_id    [TOP_N];
  logic                      best_valid [TOP_N];
  logic signed [SCORE_W-1:0] score_next [TOP_N];
  logic [ID_W-1:0]           id_next    [TOP_N];
  logic                      valid_next [TOP_N];
  logic                      here       [TOP_N];

  logic pop_fire;
  logic pop_cand;
  logic pop_report;
  logic pop_clear;
  logic out_load;

  // A report or clear waits until a pending insertion has landed.
  always_comb begin
    pop_ready  = (st == ST_RUN) &&
                 (!ins_pending || (pop_op.kind == tnds_pkg::CMD_CAND));
    pop_fire   = pop_valid && pop_ready;
    pop_cand   = pop_fire && (pop_op.kind == tnds_pkg::CMD_CAND);
    pop_report = pop_fire && (pop_op.kind == tnds_pkg::CMD_REPORT);
    pop_clear  = pop_fire && (pop_op.kind == tnds_pkg::CMD_CLEAR);
  end

  // Saturating accumulate of one product.
  always_comb begin
    sum_wide = {acc[SCORE_W-1], acc} + SUM_W'(pop_op.prod);
    if (sum_wide[SUM_W-1] != sum_wide[SCORE_W-1]) begin
      sum_sat = sum_wide[SUM_W-1] ? tnds_pkg::SCORE_MIN : tnds_pkg::SCORE_MAX;
    end else begin
      sum_sat = sum_wide[SCORE_W-1:0];
    end
    sum_pos  = !sum_sat[SCORE_W-1] && (sum_sat != '0);
    skip_now = skip || pop_op.excluded;
  end

  // Accumulator, skip flag and the insertion hand-off.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      skip        <= 1'b0;
      ins_pending <= 1'b0;
    end else begin
      ins_pending <= 1'b0;
      if (pop_cand) begin
        if (pop_op.last) begin
          acc         <= '0;
          skip        <= 1'b0;
          ins_pending <= !skip_now && pop_op.id_ok && sum_pos;
        end else begin
          acc  <= sum_sat;
          skip <= skip_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_cand && pop_op.last) begin
      ins_score <= sum_sat;
      ins_id    <= pop_op.id;
    end
  end

  // Insertion cells: a cell takes the new score if its entry is empty or beaten,
  // and shifts down from its neighbor if the neighbor's entry was empty or beaten.
  always_comb begin
    for (int k = 0; k < TOP_N; k++) begin
      here[k] = !best_valid[k] || (ins_score > best_score[k]);
    end
    for (int k = 0; k < TOP_N; k++) begin
      score_next[k] = best_score[k];
      id_next[k]    = best_id[k];
      valid_next[k] = best_valid[k];
      if ((k > 0) && here[(k > 0) ? k - 1 : 0]) begin
        score_next[k] = best_score[(k > 0) ? k - 1 : 0];
        id_next[k]    = best_id[(k > 0) ? k - 1 : 0];
        valid_next[k] = best_valid[(k > 0) ? k - 1 : 0];
      end else if (here[k]) begin
        score_next[k] = ins_score;
        id_next[k]    = ins_id;
        valid_next[k] = 1'b1;
      end
    end
  end

  // List occupancy: cleared by reset or the clear command.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TOP_N; k++) begin
        best_valid[k] <= 1'b0;
      end
    end else if (pop_clear) begin
      for (int k = 0; k < TOP_N; k++) begin
        best_valid[k] <= 1'b0;
      end
    end else if (ins_pending) begin
      for (int k = 0; k < TOP_N; k++) begin
        best_valid[k] <= valid_next[k];
      end
    end
  end

  // List contents.
  always_ff @(posedge clk) begin
    if (ins_pending) begin
      for (int k = 0; k < TOP_N; k++) begin
        best_score[k] <= score_next[k];
        best_id[k]    <= id_next[k];
      end
    end
  end

  // Output register takes a new rank when it is empty or being drained.
  assign out_load = (st == ST_REPORT) && (!out_valid || out_ready);

  // Report sequencer and result register; empty ranks read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_RUN;
      rpt_cnt     <= '0;
      out_valid   <= 1'b0;
      rank        <= '0;
      filled      <= 1'b0;
      word_id     <= '0;
      score       <= '0;
      last_result <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid   <= 1'b1;
        rank        <= RANK_W'(rpt_cnt);
        filled      <= best_valid[rpt_cnt];
        word_id     <= best_valid[rpt_cnt] ? best_id[rpt_cnt] : '0;
        score       <= best_valid[rpt_cnt] ? best_score[rpt_cnt] : '0;
        last_result <= (rpt_cnt == CNT_W'(TOP_N - 1));
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        ST_RUN: begin
          if (pop_report) begin
            st      <= ST_REPORT;
            rpt_cnt <= '0;
          end
        end
        ST_REPORT: begin
          if (out_load) begin
            if (rpt_cnt == CNT_W'(TOP_N - 1)) begin
              st <= ST_RUN;
            end else begin
              rpt_cnt <= rpt_cnt + 1'b1;
            end
          end
        end
        default: begin
          st <= ST_RUN;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/top_n_dot_product_search.sv
// ----------------------------------------------------------------------------
// top_n_dot_product_search: top-N dot-product search over streamed vectors
// Loads a query vector, accumulates the dot product of each streamed
// candidate with it, keeps the TOP_N best positive scores sorted, and
// reports or clears that list on command.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   command, elem_index, elem_value,
//                                             cand_id, cand_last, cand_excluded
//   out      output     out_valid / out_ready rank, word_id, score, filled,
//                                             last_result
//
// Query loads and candidate elements are taken one beat per clock while
// in_ready is high; each candidate element is one multiply in the front and
// one saturating add in the back. A report plays TOP_N result beats, one per
// clock while out_ready is high. After a candidate's last element, a report
// or clear waits for the list insertion to land. A stalled output fills the
// queue and then drops in_ready. Reset clears the control state and empties
// the list; the query store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module top_n_dot_product_search #(
  parameter int TOP_N      = tnds_pkg::TOP_N_DEF,
  parameter int VECTOR_DIM = tnds_pkg::VECTOR_DIM_DEF,
  parameter int VOCAB_SIZE = tnds_pkg::VOCAB_SIZE_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [tnds_pkg::CMD_W-1:0]          command,
  input  wire logic [tnds_pkg::IDX_W-1:0]          elem_index,
  input  wire logic signed [tnds_pkg::ELEM_W-1:0]  elem_value,
  input  wire logic [tnds_pkg::ID_W-1:0]           cand_id,
  input  wire logic                                cand_last,
  input  wire logic                                cand_excluded,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [tnds_pkg::RANK_W-1:0]              rank,
  output logic [tnds_pkg::ID_W-1:0]                word_id,
  output logic signed [tnds_pkg::SCORE_W-1:0]      score,
  output logic                                     filled,
  output logic                                     last_result
);

  tnds_pkg::op_t push_op;
  logic          push_valid;
  logic          push_ready;
  tnds_pkg::op_t pop_op;
  logic          pop_valid;
  logic          pop_ready;

  // Front end: query store, classification and multiply.
  tnds_front #(
    .VECTOR_DIM (VECTOR_DIM),
    .VOCAB_SIZE (VOCAB_SIZE)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .elem_index    (elem_index),
    .elem_value    (elem_value),
    .cand_id       (cand_id),
    .cand_last     (cand_last),
    .cand_excluded (cand_excluded),
    .push_op       (push_op),
    .push_valid    (push_valid),
    .push_ready    (push_ready)
  );

  // Queue between the two halves.
  tnds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_op    (push_op),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_op     (pop_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // Back end: accumulate, insert, report.
  tnds_back #(
    .TOP_N (TOP_N)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_op      (pop_op),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .rank        (rank),
    .word_id     (word_id),
    .score       (score),
    .filled      (filled),
    .last_result (last_result)
  );

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the top-N dot-product search block
// Builds a stream of query loads, candidate elements, reports and clears,
// drives it with random gaps on the input and random stalls on the output,
// and checks every ranked row against a predictor of the sorted top list.
// ----------------------------------------------------------------------------

module tb;

  localparam int CMD_W          = tnds_pkg::CMD_W;
  localparam int IDX_W          = tnds_pkg::IDX_W;
  localparam int ELEM_W         = tnds_pkg::ELEM_W;
  localparam int ID_W           = tnds_pkg::ID_W;
  localparam int RANK_W         = tnds_pkg::RANK_W;
  localparam int SCORE_W        = tnds_pkg::SCORE_W;
  localparam int TOP_N_DEF      = tnds_pkg::TOP_N_DEF;
  localparam int VECTOR_DIM_DEF = tnds_pkg::VECTOR_DIM_DEF;
  localparam int VOCAB_SIZE_DEF = tnds_pkg::VOCAB_SIZE_DEF;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = tnds_pkg::SCORE_MAX;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = tnds_pkg::SCORE_MIN;

  localparam int  LONG_HOLD    = 300;
  localparam int  TAIL_OPS     = 40;
  localparam int  RANDOM_OPS   = 60;
  localparam int  DRAIN_CYCLES = 40;
  localparam int  LIMIT_CYCLES = 200000;
  localparam int  ID_MAX       = (1 << ID_W) - 1;

  // One input beat plus the flags that steer the bench around it.
  typedef struct packed {
    tnds_pkg::op_kind_t        cmd;
    logic [IDX_W-1:0]          idx;
    logic signed [ELEM_W-1:0]  val;
    logic [ID_W-1:0]           id;
    logic                      last;
    logic                      excl;
    bit                        hold_out;
    bit                        wait_drain;
  } search_op_t;

  // One ranked row of a report.
  typedef struct packed {
    logic [RANK_W-1:0]          rank;
    logic [ID_W-1:0]            wid;
    logic signed [SCORE_W-1:0]  sc;
    logic                       filled;
    logic                       fin;
  } rank_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        in_valid      = 1'b0;
  logic                        in_ready;
  logic [CMD_W-1:0]            command       = '0;
  logic [IDX_W-1:0]            elem_index    = '0;
  logic signed [ELEM_W-1:0]    elem_value    = '0;
  logic [ID_W-1:0]             cand_id       = '0;
  logic                        cand_last     = 1'b0;
  logic                        cand_excluded = 1'b0;
  logic                        out_valid;
  logic                        out_ready     = 1'b0;
  logic [RANK_W-1:0]           rank;
  logic [ID_W-1:0]             word_id;
  logic signed [SCORE_W-1:0]   score;
  logic                        filled;
  logic                        last_result;

  // Stimulus and expectation stores.
  search_op_t pending_ops[$];
  rank_row_t  rows_due[$];
  search_op_t cur;

  // Generator view of the query, so candidates only read loaded entries.
  int query_gen [0:VECTOR_DIM_DEF-1];
  bit query_set [0:VECTOR_DIM_DEF-1];
  int loaded_idx[$];
  bit hold_flag_next  = 1'b0;
  bit drain_flag_next = 1'b0;

  // Predictor state.
  logic signed [ELEM_W-1:0]  query_vec [0:VECTOR_DIM_DEF-1];
  logic signed [SCORE_W-1:0] dot_acc  = '0;
  bit                        skip_cand = 1'b0;
  logic signed [SCORE_W-1:0] top_score [0:TOP_N_DEF-1];
  logic [ID_W-1:0]           top_id    [0:TOP_N_DEF-1];
  bit                        top_held  [0:TOP_N_DEF-1];

  // Bench bookkeeping.
  int cycles     = 0;
  int accepted   = 0;
  int mismatches = 0;
  int gap_left   = 0;
  int stall_left = 0;
  int hold_left  = 0;
  bit hold_go    = 1'b0;
  bit in_acc     = 1'b0;
  bit idle_ok    = 1'b0;

  top_n_dot_product_search dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .elem_index    (elem_index),
    .elem_value    (elem_value),
    .cand_id       (cand_id),
    .cand_last     (cand_last),
    .cand_excluded (cand_excluded),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .rank          (rank),
    .word_id       (word_id),
    .score         (score),
    .filled        (filled),
    .last_result   (last_result)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Appends one beat to the stimulus and tracks which query entries exist.
  task automatic queue_op(tnds_pkg::op_kind_t c, int idx, int v, int id, bit last,
                          bit excl);
    search_op_t op;
    op.cmd        = c;
    op.idx        = IDX_W'(idx);
    op.val        = ELEM_W'(v);
    op.id         = ID_W'(id);
    op.last       = last;
    op.excl       = excl;
    op.hold_out   = hold_flag_next;
    op.wait_drain = drain_flag_next;
    hold_flag_next  = 1'b0;
    drain_flag_next = 1'b0;
    if (c == tnds_pkg::CMD_LOAD) begin
      query_gen[idx] = v;
      if (!query_set[idx]) begin
        query_set[idx] = 1'b1;
        loaded_idx.push_back(idx);
      end
    end
    pending_ops.push_back(op);
  endtask

  // Appends a candidate with random elements over loaded query entries.
  // Most products are made positive so that the list fills up.
  task automatic queue_candidate(int id, int len, int excl_pct, bit end_it);
    int idx;
    int v;
    for (int e = 0; e < len; e++) begin
      idx = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
      v = int'($urandom_range(0, 65535)) - 32768;
      if ($urandom_range(0, 9) < 8 && ((v < 0) != (query_gen[idx] < 0))) v = -v;
      queue_op(tnds_pkg::CMD_CAND, idx, v, id, end_it && (e == len - 1),
               $urandom_range(0, 99) < excl_pct);
    end
  endtask

  // Advances the predicted query, accumulator and top list by one beat and
  // queues the rows that a report should produce.
  task automatic score_and_rank(tnds_pkg::op_kind_t op, logic [IDX_W-1:0] idx,
                                logic signed [ELEM_W-1:0] val, logic [ID_W-1:0] id,
                                logic last, logic excl);
    longint    sum;
    int        pos;
    rank_row_t row;
    case (op)
      tnds_pkg::CMD_LOAD: begin
        if (idx < VECTOR_DIM_DEF) query_vec[idx] = val;
      end
      tnds_pkg::CMD_CAND: begin
        if (excl) skip_cand = 1'b1;
        if (idx < VECTOR_DIM_DEF) begin
          sum = longint'(dot_acc) + longint'(query_vec[idx]) * longint'(val);
          if (sum > longint'(SCORE_MAX)) sum = longint'(SCORE_MAX);
          if (sum < longint'(SCORE_MIN)) sum = longint'(SCORE_MIN);
          dot_acc = sum[SCORE_W-1:0];
        end
        if (last) begin
          if (!skip_cand && id < VOCAB_SIZE_DEF && dot_acc > 0) begin
            // A new score must strictly beat a held one, so ties keep order.
            pos = TOP_N_DEF;
            for (int k = TOP_N_DEF - 1; k >= 0; k--)
              if (!top_held[k] || dot_acc > top_score[k]) pos = k;
            if (pos < TOP_N_DEF) begin
              for (int k = TOP_N_DEF - 1; k > pos; k--) begin
                top_score[k] = top_score[k-1];
                top_id[k]    = top_id[k-1];
                top_held[k]  = top_held[k-1];
              end
              top_score[pos] = dot_acc;
              top_id[pos]    = id;
              top_held[pos]  = 1'b1;
            end
          end
          dot_acc   = '0;
          skip_cand = 1'b0;
        end
      end
      tnds_pkg::CMD_REPORT: begin
        for (int k = 0; k < TOP_N_DEF; k++) begin
          row.rank   = RANK_W'(k);
          row.wid    = top_held[k] ? top_id[k] : '0;
          row.sc     = top_held[k] ? top_score[k] : '0;
          row.filled = top_held[k];
          row.fin    = (k == TOP_N_DEF - 1);
          rows_due.push_back(row);
        end
      end
      tnds_pkg::CMD_CLEAR: begin
        top_score = '{default: '0};
        top_id    = '{default: '0};
        top_held  = '{default: 1'b0};
      end
      default: ;
    endcase
  endtask

  // Compares one output beat against the oldest expected row.
  task automatic check_row();
    rank_row_t want;
    if (rows_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected row: rank %0d id %0d score %0d filled %0b last %0b",
                 rank, word_id, score, filled, last_result);
    end else begin
      want = rows_due.pop_front();
      if (want.rank !== rank || want.wid !== word_id || want.sc !== score ||
          want.filled !== filled || want.fin !== last_result) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("row mismatch: expected rank %0d id %0d score %0d filled %0b last %0b",
                   want.rank, want.wid, want.sc, want.filled, want.fin);
          $display("              got rank %0d id %0d score %0d filled %0b last %0b",
                   rank, word_id, score, filled, last_result);
        end
      end
    end
  endtask

  // Monitor: takes input beats into the predictor and checks output beats.
  always @(posedge clk) begin
    cycles = cycles + 1;
    in_acc = in_valid && in_ready;
    if (in_acc) begin
      accepted++;
      if (cur.hold_out) hold_go = 1'b1;
      score_and_rank(tnds_pkg::op_kind_t'(command), elem_index, elem_value, cand_id,
                     cand_last, cand_excluded);
    end
    if (out_valid === 1'b1 && out_ready) check_row();
    // Idling pauses in every fourth stretch and stops for the tail of the run.
    idle_ok = (pending_ops.size() >= TAIL_OPS) && ((cycles / 256) % 4 != 3);
    if (cycles >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Driver: offers the next beat, holding it until it is taken.
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_acc)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() == 0 ||
                   (pending_ops[0].wait_drain && rows_due.size() != 0)) begin
        in_valid <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else begin
        cur = pending_ops.pop_front();
        in_valid      <= 1'b1;
        command       <= cur.cmd;
        elem_index    <= cur.idx;
        elem_value    <= cur.val;
        cand_id       <= cur.id;
        cand_last     <= cur.last;
        cand_excluded <= cur.excl;
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_ok && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Builds the stimulus, runs reset, and waits for everything to drain.
  initial begin
    int total_ops;
    int first;
    int roll;
    int rand_made;
    int id;

    query_gen = '{default: 0};
    query_set = '{default: 1'b0};
    query_vec = '{default: '0};
    top_score = '{default: '0};
    top_id    = '{default: '0};
    top_held  = '{default: 1'b0};

    // Report of the empty list, then query extremes.
    queue_op(tnds_pkg::CMD_REPORT, 0, 0, 0, 0, 0);
    queue_op(tnds_pkg::CMD_LOAD, 0, 32767, 0, 0, 0);
    queue_op(tnds_pkg::CMD_LOAD, 255, -32768, ID_MAX, 1, 1);
    queue_op(tnds_pkg::CMD_LOAD, 1, 4096, 0, 0, 0);
    queue_op(tnds_pkg::CMD_LOAD, 128, -4096, 0, 0, 0);
    // Single-element candidates, one at the top id, then a tie.
    queue_op(tnds_pkg::CMD_CAND, 0, 4096, 5, 1, 0);
    queue_op(tnds_pkg::CMD_CAND, 255, -32768, ID_MAX, 1, 0);
    queue_op(tnds_pkg::CMD_CAND, 0, 4096, 9, 1, 0);
    // Exclusion on an early element sticks to the whole candidate.
    queue_op(tnds_pkg::CMD_CAND, 255, -32768, 11, 0, 1);
    queue_op(tnds_pkg::CMD_CAND, 0, 1, 11, 1, 0);
    // Zero and negative scores stay out of the list.
    queue_op(tnds_pkg::CMD_CAND, 1, 0, 12, 1, 0);
    queue_op(tnds_pkg::CMD_CAND, 128, 32767, 13, 1, 0);
    queue_op(tnds_pkg::CMD_REPORT, 0, 0, 0, 0, 0);
    // Clear and report in the middle of a candidate keep the running sum.
    queue_op(tnds_pkg::CMD_CAND, 0, 100, 14, 0, 0);
    queue_op(tnds_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
    queue_op(tnds_pkg::CMD_REPORT, 0, 0, 0, 0, 0);
    queue_op(tnds_pkg::CMD_CAND, 1, 200, 14, 1, 0);
    // Exclusion seen only on the last element.
    queue_op(tnds_pkg::CMD_CAND, 1, 4096, 15, 1, 1);
    queue_op(tnds_pkg::CMD_REPORT, 0, 0, 0, 0, 0);

    // A candidate of several large products that ends on a small negative
    // term, so it should land at the top of the list.
    for (int k = 0; k < 4; k++) queue_op(tnds_pkg::CMD_CAND, 255, -32768, 77, 0, 0);
    queue_op(tnds_pkg::CMD_CAND, 0, -1, 77, 0, 0);
    queue_op(tnds_pkg::CMD_CAND, 1, -5, 77, 1, 0);
    queue_op(tnds_pkg::CMD_REPORT, 0, 0, 0, 0, 0);

    // Output held off while candidates and reports keep coming, then a
    // report that waits for every outstanding row.
    hold_flag_next = 1'b1;
    queue_op(tnds_pkg::CMD_REPORT, 0, 0, 0, 0, 0);
    for (int k = 0; k < 10; k++) begin
      queue_candidate(100 + k, 1, 0, 1'b1);
      if (k % 4 == 1) queue_op(tnds_pkg::CMD_REPORT, 0, 0, 0, 0, 0);
    end
    drain_flag_next = 1'b1;
    queue_op(tnds_pkg::CMD_REPORT, 0, 0, 0, 0, 0);

    // Random part: mostly whole candidates, some loads, reports and clears,
    // and now and then a candidate that never ends before the next command.
    rand_made = 0;
    while (rand_made < RANDOM_OPS) begin
      first = pending_ops.size();
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        queue_op(tnds_pkg::CMD_LOAD, $urandom_range(0, 255),
                 int'($urandom_range(0, 65535)) - 32768,
                 $urandom_range(0, ID_MAX), $urandom_range(0, 1), $urandom_range(0, 1));
      end else if (roll < 78) begin
        case ($urandom_range(0, 9))
          0:       id = 0;
          1:       id = ID_MAX;
          default: id = $urandom_range(0, ID_MAX);
        endcase
        queue_candidate(id, $urandom_range(1, 4), 4, $urandom_range(0, 19) != 0);
      end else if (roll < 96) begin
        queue_op(tnds_pkg::CMD_REPORT, $urandom_range(0, 255),
                 int'($urandom_range(0, 65535)) - 32768,
                 $urandom_range(0, ID_MAX), $urandom_range(0, 1), $urandom_range(0, 1));
      end else begin
        queue_op(tnds_pkg::CMD_CLEAR, $urandom_range(0, 255),
                 int'($urandom_range(0, 65535)) - 32768,
                 $urandom_range(0, ID_MAX), $urandom_range(0, 1), $urandom_range(0, 1));
      end
      rand_made += pending_ops.size() - first;
    end
    queue_op(tnds_pkg::CMD_REPORT, 0, 0, 0, 0, 0);
    total_ops = pending_ops.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (accepted < total_ops) @(negedge clk);
    while (rows_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && rows_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
